### rtl/core/pgmsp_pkg.sv
package pgmsp_pkg;

  // Width of the width and height accumulators, and of the pixel counter.
  localparam int DIM_BITS   = 16;
  localparam int COUNT_BITS = 32;

  // Width of the dimension fields on the result word.
  localparam int OUT_DIM_BITS = 16;

  // Header characters.
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_FIVE    = 8'h35;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_MAG0     = 4'd0,
    PH_MAG1     = 4'd1,
    PH_MAG2     = 4'd2,
    PH_AFTERMAG = 4'd3,
    PH_COMMENT  = 4'd4,
    PH_WIDTH    = 4'd5,
    PH_HEIGHT   = 4'd6,
    PH_MAX0     = 4'd7,
    PH_MAX1     = 4'd8,
    PH_MAX2     = 4'd9,
    PH_MAX3     = 4'd10,
    PH_PIXELS   = 4'd11
  } phase_t;

  // Status codes; ST_PARSING also means that no error is pending.
  typedef enum logic [2:0] {
    ST_PARSING  = 3'd0,
    ST_OK       = 3'd1,
    ST_BADMAGIC = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_BADMAX   = 3'd4,
    ST_MISMATCH = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  // Input word: one byte of the file.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Result word: one per input byte.
  typedef struct packed {
    logic                    pixel_valid;
    logic [7:0]              pixel_value;
    logic                    header_done;
    logic [OUT_DIM_BITS-1:0] image_width;
    logic [OUT_DIM_BITS-1:0] image_height;
    logic [2:0]              status;
    logic                    file_end;
  } out_word_t;

endpackage

### rtl/core/pgmsp_in_if.sv
interface pgmsp_in_if
  import pgmsp_pkg::*;
();

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### rtl/core/pgmsp_out_if.sv
interface pgmsp_out_if
  import pgmsp_pkg::*;
();

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### rtl/core/pgm_p5_stream_parser_core.sv
// Binary PGM (P5) stream parser. Feed the file one byte per word on in_ch, with
// last_byte set on the final byte; every input word yields exactly one result
// word on out_ch, through the output register, carrying the pixel (if the byte is image
// data), the parsed width and height, a header-done flag and a status code that
// is final on the word marked file_end. The header must be "P5\n", an optional
// comment line starting with '#', decimal width and height each ended by one
// non-digit, then "255\n". Errors are sticky until the last byte, after which
// the parser is back at its reset state for the next file. It takes one
// byte per cycle unless stalled; the only stall comes from the
// single output register, so in_ch.ready is low only while a result waits and
// out_ch.ready is low. The width-times-height product is kept in a register
// that follows the parsed dimensions each cycle, and the pixel count is checked
// against it on the last byte.
module pgm_p5_stream_parser_core
  import pgmsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  pgmsp_in_if.sink     in_ch,
  pgmsp_out_if.source  out_ch
);

  localparam int PROD_BITS = 2 * DIM_BITS;
  localparam int CMP_BITS  = (PROD_BITS > COUNT_BITS) ? PROD_BITS : COUNT_BITS;

  // Multiply by ten and add a digit; the top bit flags a result beyond the
  // dimension range, and the value then saturates at all ones.
  function automatic logic [DIM_BITS:0] add_digit(input logic [DIM_BITS-1:0] v,
                                                  input logic [3:0] d);
    logic [DIM_BITS+3:0] t;
    t = ((DIM_BITS + 4)'(v) << 3) + ((DIM_BITS + 4)'(v) << 1) + (DIM_BITS + 4)'(d);
    if (|t[DIM_BITS+3:DIM_BITS]) begin
      return {1'b1, {DIM_BITS{1'b1}}};
    end
    return {1'b0, t[DIM_BITS-1:0]};
  endfunction

  phase_t                phase_r, phase_nxt;
  status_t               err_r, err_nxt;
  logic [DIM_BITS-1:0]   width_r, width_nxt;
  logic [DIM_BITS-1:0]   height_r, height_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PROD_BITS-1:0]  prod_r;

  logic                  out_valid_r;
  out_word_t             out_word_r, out_word_nxt;

  logic                  in_fire;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [DIM_BITS:0]     width_add;
  logic [DIM_BITS:0]     height_add;
  logic                  pix_pass;
  logic [DIM_BITS+OUT_DIM_BITS-1:0] width_ext;
  logic [DIM_BITS+OUT_DIM_BITS-1:0] height_ext;

  // Handshake: take a word whenever the output register is free or being emptied.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // Digit decode and the two accumulator updates.
  assign is_digit   = (in_ch.data.data_byte >= CH_ZERO) && (in_ch.data.data_byte <= CH_NINE);
  assign digit      = in_ch.data.data_byte[3:0];
  assign width_add  = add_digit(width_r, digit);
  assign height_add = add_digit(height_r, digit);

  // Next state of the parser.
  always_comb begin
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    count_nxt  = count_r;
    pix_pass   = 1'b0;
    if (err_r == ST_PARSING) begin
      unique case (phase_r)
        PH_MAG0: begin
          if (in_ch.data.data_byte == CH_P) phase_nxt = PH_MAG1;
          else err_nxt = ST_BADMAGIC;
        end
        PH_MAG1: begin
          if (in_ch.data.data_byte == CH_FIVE) phase_nxt = PH_MAG2;
          else err_nxt = ST_BADMAGIC;
        end
        PH_MAG2: begin
          if (in_ch.data.data_byte == CH_NEWLINE) phase_nxt = PH_AFTERMAG;
          else err_nxt = ST_BADMAGIC;
        end
        PH_AFTERMAG: begin
          if (in_ch.data.data_byte == CH_HASH) begin
            phase_nxt = PH_COMMENT;
          end else if (is_digit) begin
            width_nxt = width_add[DIM_BITS-1:0];
            if (width_add[DIM_BITS]) err_nxt = ST_OVERFLOW;
            phase_nxt = PH_WIDTH;
          end else begin
            phase_nxt = PH_HEIGHT;
          end
        end
        PH_COMMENT: begin
          if (in_ch.data.data_byte == CH_NEWLINE) phase_nxt = PH_WIDTH;
        end
        PH_WIDTH: begin
          if (is_digit) begin
            width_nxt = width_add[DIM_BITS-1:0];
            if (width_add[DIM_BITS]) err_nxt = ST_OVERFLOW;
          end else begin
            phase_nxt = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if (is_digit) begin
            height_nxt = height_add[DIM_BITS-1:0];
            if (height_add[DIM_BITS]) err_nxt = ST_OVERFLOW;
          end else begin
            phase_nxt = PH_MAX0;
          end
        end
        PH_MAX0: begin
          if (in_ch.data.data_byte == CH_TWO) phase_nxt = PH_MAX1;
          else err_nxt = ST_BADMAX;
        end
        PH_MAX1: begin
          if (in_ch.data.data_byte == CH_FIVE) phase_nxt = PH_MAX2;
          else err_nxt = ST_BADMAX;
        end
        PH_MAX2: begin
          if (in_ch.data.data_byte == CH_FIVE) phase_nxt = PH_MAX3;
          else err_nxt = ST_BADMAX;
        end
        PH_MAX3: begin
          if (in_ch.data.data_byte == CH_NEWLINE) phase_nxt = PH_PIXELS;
          else err_nxt = ST_BADMAX;
        end
        PH_PIXELS: begin
          // A full counter cannot take another pixel.
          if (&count_r) begin
            err_nxt = ST_MISMATCH;
          end else begin
            count_nxt = count_r + 1'b1;
            pix_pass  = 1'b1;
          end
        end
        default: phase_nxt = PH_MAG0;
      endcase
    end
  end

  assign width_ext  = (DIM_BITS + OUT_DIM_BITS)'(width_nxt);
  assign height_ext = (DIM_BITS + OUT_DIM_BITS)'(height_nxt);

  // Result word for the current byte, built from the updated state.
  always_comb begin
    out_word_nxt              = '0;
    out_word_nxt.pixel_valid  = pix_pass;
    out_word_nxt.pixel_value  = pix_pass ? in_ch.data.data_byte : 8'd0;
    out_word_nxt.header_done  = (err_nxt == ST_PARSING) && (phase_nxt == PH_PIXELS);
    out_word_nxt.image_width  = width_ext[OUT_DIM_BITS-1:0];
    out_word_nxt.image_height = height_ext[OUT_DIM_BITS-1:0];
    out_word_nxt.status       = err_nxt;
    out_word_nxt.file_end     = in_ch.data.last_byte;
    if (in_ch.data.last_byte && (err_nxt == ST_PARSING)) begin
      if (phase_nxt != PH_PIXELS) begin
        out_word_nxt.status = ST_TRUNC;
      end else if (CMP_BITS'(count_nxt) == CMP_BITS'(prod_r)) begin
        out_word_nxt.status = ST_OK;
      end else begin
        out_word_nxt.status = ST_MISMATCH;
      end
    end
  end

  // Parser state; the last byte of a file returns everything to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAG0;
      err_r    <= ST_PARSING;
      width_r  <= '0;
      height_r <= '0;
      count_r  <= '0;
    end else if (in_fire) begin
      if (in_ch.data.last_byte) begin
        phase_r  <= PH_MAG0;
        err_r    <= ST_PARSING;
        width_r  <= '0;
        height_r <= '0;
        count_r  <= '0;
      end else begin
        phase_r  <= phase_nxt;
        err_r    <= err_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // Image size product; the dimensions settle several bytes before any pixel.
  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(width_r) * PROD_BITS'(height_r);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule
